/* rtl/core/jtn_pkg.sv */
`timescale 1ns / 1ps

package jtn_pkg;

  typedef logic [3:0] tap_code_t;

  // TAP state numbering used throughout the design.
  localparam tap_code_t S_TLR   = 4'd0;
  localparam tap_code_t S_IDLE  = 4'd1;
  localparam tap_code_t S_SELDR = 4'd2;
  localparam tap_code_t S_CAPDR = 4'd3;
  localparam tap_code_t S_SHDR  = 4'd4;
  localparam tap_code_t S_EX1DR = 4'd5;
  localparam tap_code_t S_PAUDR = 4'd6;
  localparam tap_code_t S_EX2DR = 4'd7;
  localparam tap_code_t S_UPDDR = 4'd8;
  localparam tap_code_t S_SELIR = 4'd9;
  localparam tap_code_t S_CAPIR = 4'd10;
  localparam tap_code_t S_SHIR  = 4'd11;
  localparam tap_code_t S_EX1IR = 4'd12;
  localparam tap_code_t S_PAUIR = 4'd13;
  localparam tap_code_t S_EX2IR = 4'd14;
  localparam tap_code_t S_UPDIR = 4'd15;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] MODE_GOTO      = 2'd0;
  localparam logic [1:0] MODE_RESET     = 2'd1;
  localparam logic [1:0] MODE_SHIFT_END = 2'd2;
  // The fourth kind has no meaning and is dropped.
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  localparam int NAV_MAX_BITS = 7;
  localparam int RESET_BITS   = 6;
  localparam int BIT_CNT_W    = $clog2(NAV_MAX_BITS);

  typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

  // Request to the step unit.
  typedef struct packed {
    logic      force_one;
    tap_code_t pos;
    tap_code_t tgt;
  } step_req_t;

  // Answer of the step unit.
  typedef struct packed {
    logic      tms;
    tap_code_t nxt;
  } step_rsp_t;

  // Successor of a TAP state when TMS is high.
  function automatic tap_code_t tms_one_next(input tap_code_t s);
    tap_code_t r;
    case (s)
      S_TLR:   r = S_TLR;
      S_IDLE:  r = S_SELDR;
      S_SELDR: r = S_SELIR;
      S_CAPDR: r = S_EX1DR;
      S_SHDR:  r = S_EX1DR;
      S_EX1DR: r = S_UPDDR;
      S_PAUDR: r = S_EX2DR;
      S_EX2DR: r = S_UPDDR;
      S_UPDDR: r = S_SELDR;
      S_SELIR: r = S_TLR;
      S_CAPIR: r = S_EX1IR;
      S_SHIR:  r = S_EX1IR;
      S_EX1IR: r = S_UPDIR;
      S_PAUIR: r = S_EX2IR;
      S_EX2IR: r = S_UPDIR;
      default: r = S_SELDR;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/jtn_step.sv */
`timescale 1ns / 1ps

module jtn_step (
  input  jtn_pkg::step_req_t req,
  output jtn_pkg::step_rsp_t rsp
);
  import jtn_pkg::*;

  tap_code_t z_nxt;
  tap_code_t o_nxt;
  logic      take0;

  // One routing decision: the zero and one successors and which to take.
  always_comb begin
    z_nxt = S_IDLE;
    o_nxt = S_SELDR;
    take0 = 1'b0;
    case (req.pos)
      S_TLR: begin
        z_nxt = S_IDLE;  take0 = 1'b1;
      end
      S_IDLE: begin
        o_nxt = S_SELDR; take0 = 1'b0;
      end
      S_SELDR: begin
        z_nxt = S_CAPDR; o_nxt = S_SELIR;
        take0 = req.tgt inside {[S_CAPDR:S_UPDDR]};
      end
      S_SELIR: begin
        z_nxt = S_CAPIR; o_nxt = S_TLR;
        take0 = req.tgt inside {[S_CAPIR:S_UPDIR]};
      end
      S_CAPDR: begin
        z_nxt = S_SHDR;  o_nxt = S_EX1DR; take0 = (req.tgt == S_SHDR);
      end
      S_SHDR: begin
        o_nxt = S_EX1DR; take0 = 1'b0;
      end
      S_EX1DR: begin
        z_nxt = S_PAUDR; o_nxt = S_UPDDR;
        take0 = req.tgt inside {[S_SHDR:S_EX2DR]};
      end
      S_PAUDR: begin
        o_nxt = S_EX2DR; take0 = 1'b0;
      end
      S_EX2DR: begin
        z_nxt = S_SHDR;  o_nxt = S_UPDDR;
        take0 = req.tgt inside {[S_SHDR:S_PAUDR]};
      end
      S_CAPIR: begin
        z_nxt = S_SHIR;  o_nxt = S_EX1IR; take0 = (req.tgt == S_SHIR);
      end
      S_SHIR: begin
        o_nxt = S_EX1IR; take0 = 1'b0;
      end
      S_EX1IR: begin
        z_nxt = S_PAUIR; o_nxt = S_UPDIR;
        take0 = req.tgt inside {[S_SHIR:S_EX2IR]};
      end
      S_PAUIR: begin
        o_nxt = S_EX2IR; take0 = 1'b0;
      end
      S_EX2IR: begin
        z_nxt = S_SHIR;  o_nxt = S_UPDIR;
        take0 = req.tgt inside {[S_SHIR:S_PAUIR]};
      end
      default: begin
        // Update-DR and Update-IR.
        z_nxt = S_IDLE;  o_nxt = S_SELDR; take0 = (req.tgt == S_IDLE);
      end
    endcase
  end

  always_comb begin
    if (req.force_one) begin
      rsp.tms = 1'b1;
      rsp.nxt = tms_one_next(req.pos);
    end else begin
      rsp.tms = ~take0;
      rsp.nxt = take0 ? z_nxt : o_nxt;
    end
  end

endmodule

/* rtl/core/jtag_tap_navigator.sv */
`timescale 1ns / 1ps

// Channel  | Direction | tdata (low bit up)                 | side band
// ---------+-----------+------------------------------------+----------------------
// in_      | slave     | [3:0] target_state, [7:4] zero     | tuser[1:0] mode
// out_     | master    | [0] tms_bit, [4:1] state_after,    | tlast marks the final
//          |           | [7:5] zero                         | bit of a request
//
// A request is accepted in the idle state; the walk then emits one TMS bit per
// cycle while the output is free, at most seven bits for a navigation and six
// for a reset. The bits come from the single shared step unit, which decides
// each TMS bit from the registered TAP position. Shift-end, unused-mode and
// already-at-target requests are absorbed in their accept cycle.
// Reset is synchronous and active low; it places the position at Run-Test/Idle.
// A stalled output holds its transfer and freezes the walk; the next request
// may be accepted while the final bit of the previous one is still waiting.

module jtag_tap_navigator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] target_state, [7:4] zero
  input  logic [1:0] in_tuser,   // [1:0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] tms_bit, [4:1] state_after, [7:5] zero
  output logic       out_tlast
);
  import jtn_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  tap_code_t  pos_r, pos_nxt;
  tap_code_t  tgt_r, tgt_nxt;
  logic       rst_walk_r, rst_walk_nxt;
  bit_cnt_t   cnt_r, cnt_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_tms_r, out_tms_nxt;
  tap_code_t  out_state_r, out_state_nxt;
  logic       out_last_r, out_last_nxt;

  step_req_t  step_req;
  step_rsp_t  step_rsp;

  logic       in_xfer;
  logic       out_free;
  logic       walk_done;
  logic [1:0] req_mode;
  tap_code_t  req_tgt;

  assign req_mode = in_tuser;
  assign req_tgt  = in_tdata[3:0];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  // The output register can take a new bit when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;

  // The shared step unit always works on the registered position.
  assign step_req.force_one = rst_walk_r;
  assign step_req.pos       = pos_r;
  assign step_req.tgt       = tgt_r;

  jtn_step u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  // A reset walk ends after its sixth bit; a navigation ends at the target
  // or after the seventh bit, whichever comes first.
  always_comb begin
    if (rst_walk_r) begin
      walk_done = (cnt_r == bit_cnt_t'(RESET_BITS - 1));
    end else begin
      walk_done = (step_rsp.nxt == tgt_r) || (cnt_r == bit_cnt_t'(NAV_MAX_BITS - 1));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    tgt_nxt       = tgt_r;
    rst_walk_nxt  = rst_walk_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tms_nxt   = out_tms_r;
    out_state_nxt = out_state_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          tgt_nxt = req_tgt;
          cnt_nxt = '0;
          case (req_mode)
            MODE_GOTO: begin
              rst_walk_nxt = 1'b0;
              if (req_tgt != pos_r) begin
                state_nxt = ST_RUN;
              end
            end
            MODE_RESET: begin
              rst_walk_nxt = 1'b1;
              state_nxt    = ST_RUN;
            end
            MODE_SHIFT_END: begin
              // The last shifted bit carried TMS high out of the shift state.
              if (pos_r == S_SHDR) begin
                pos_nxt = S_EX1DR;
              end else if (pos_r == S_SHIR) begin
                pos_nxt = S_EX1IR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tms_nxt   = step_rsp.tms;
          out_state_nxt = step_rsp.nxt;
          out_last_nxt  = walk_done;
          pos_nxt       = step_rsp.nxt;
          cnt_nxt       = cnt_r + 1'b1;
          if (walk_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= S_IDLE;
      rst_walk_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rst_walk_r  <= rst_walk_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r       <= tgt_nxt;
    out_tms_r   <= out_tms_nxt;
    out_state_r <= out_state_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_state_r, out_tms_r};
  assign out_tlast  = out_last_r;

endmodule

/* rtl/core/jtn_checker.sv */
`timescale 1ns / 1ps

module jtn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import jtn_pkg::*;

  // A stalled output transfer keeps its bit and its state.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transfer changed while stalled");

  // A reset request always emits bits, so the input closes right after it.
  a_reset_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_RESET) |=> !in_tready)
    else $error("reset request did not start a walk");

  // Shift-end and unused requests emit nothing and leave the input open.
  a_noemit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_SHIFT_END || in_tuser == MODE_UNUSED)
    |=> in_tready)
    else $error("silent request blocked the input");

  // A state reached only with TMS high must be shown with TMS high and zero upper bits.
  a_tms_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[4:1] == S_TLR || out_tdata[4:1] == S_SELDR ||
                   out_tdata[4:1] == S_SELIR) |-> out_tdata[0] && (out_tdata[7:5] == 3'b000))
    else $error("state reached only by TMS high shown with TMS low");

endmodule

bind jtag_tap_navigator jtn_checker u_jtn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
